/* hw/rtl/mvaa_pkg.sv */
// package: widths, config codes and shared types of the mesh volume and area accumulator
`timescale 1ns / 1ps
package mvaa_pkg;

    localparam int COORD_BITS    = 20;
    localparam int IN_W          = 20;
    localparam int MAX_TRIANGLES = 65536;
    localparam int CNT_W         = 17;
    localparam int CFG_W         = 20;
    localparam int MAG_W         = 43;
    localparam int TRI_W         = 64;
    localparam int Q_W           = 88;
    localparam int ROOT_W        = 44;
    localparam int SUM_W         = 64;
    localparam int OUT_W         = 63;

    localparam logic [0:0] REG_SOLID = 1'd0;
    localparam logic [0:0] REG_LIMIT = 1'd1;

    typedef struct packed {
        logic [MAG_W-1:0]        mx;
        logic [MAG_W-1:0]        my;
        logic [MAG_W-1:0]        mz;
        logic signed [TRI_W-1:0] triple;
        logic                    proj;
        logic                    last;
    } t_side;

    // keep the low COORD_BITS bits and sign-extend from the top one
    function automatic logic signed [IN_W-1:0] coord(input logic [IN_W-1:0] raw);
        logic signed [IN_W-1:0] s;
        s = $signed(raw << (IN_W - COORD_BITS));
        return s >>> (IN_W - COORD_BITS);
    endfunction

endpackage

/* hw/rtl/mvaa_isqrt.sv */
// pipelined integer square root, one root bit per stage, with side data
`timescale 1ns / 1ps
module mvaa_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_ce,
    input  logic                     i_vld,
    input  logic [mvaa_pkg::Q_W-1:0] i_q,
    input  mvaa_pkg::t_side          i_side,
    output logic                     o_vld,
    output logic [mvaa_pkg::ROOT_W-1:0] o_root,
    output mvaa_pkg::t_side          o_side
);
    import mvaa_pkg::*;

    logic [Q_W-1:0]    r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    t_side             r_side [ROOT_W];
    logic              r_vld  [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            localparam int B = ROOT_W - 1 - k;
            logic [Q_W-1:0]    rem_in;
            logic [ROOT_W-1:0] root_in;
            t_side             side_in;
            logic              vld_in;
            logic [Q_W-1:0]    trial;

            if (k == 0) begin : g_first
                assign rem_in  = i_q;
                assign root_in = '0;
                assign side_in = i_side;
                assign vld_in  = i_vld;
            end else begin : g_next
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
                assign side_in = r_side[k-1];
                assign vld_in  = r_vld[k-1];
            end

            // (r + 2^b)^2 - r^2
            assign trial = (Q_W'(root_in) << (B + 1)) | (Q_W'(1) << (2 * B));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_ce) begin
                    r_vld[k] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_side[k] <= side_in;
                    if (rem_in >= trial) begin
                        r_rem[k]  <= rem_in - trial;
                        r_root[k] <= root_in | (ROOT_W'(1) << B);
                    end else begin
                        r_rem[k]  <= rem_in;
                        r_root[k] <= root_in;
                    end
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

/* hw/rtl/mesh_volume_area_accumulator_core.sv */
// top level: per-triangle volume, area and projected area accumulator
// throughput: one triangle per cycle while the output is not stalled;
//   7 arithmetic stages, a 44-stage root pipeline (one root bit per stage),
//   then the accumulators feeding the output register
// the whole pipeline freezes only while a result is held stalled at the output
// reset: valid bits, sums, count and overflow clear; solid_enable 1, limit 0
`timescale 1ns / 1ps
module mesh_volume_area_accumulator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [mvaa_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mvaa_pkg::IN_W-1:0]     i_a_x,
    input  logic [mvaa_pkg::IN_W-1:0]     i_a_y,
    input  logic [mvaa_pkg::IN_W-1:0]     i_a_z,
    input  logic [mvaa_pkg::IN_W-1:0]     i_b_x,
    input  logic [mvaa_pkg::IN_W-1:0]     i_b_y,
    input  logic [mvaa_pkg::IN_W-1:0]     i_b_z,
    input  logic [mvaa_pkg::IN_W-1:0]     i_c_x,
    input  logic [mvaa_pkg::IN_W-1:0]     i_c_y,
    input  logic [mvaa_pkg::IN_W-1:0]     i_c_z,
    input  logic                          i_last_triangle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mvaa_pkg::OUT_W-1:0]    o_six_volume,
    output logic [mvaa_pkg::OUT_W-1:0]    o_twice_area,
    output logic [mvaa_pkg::OUT_W-1:0]    o_twice_proj_x,
    output logic [mvaa_pkg::OUT_W-1:0]    o_twice_proj_y,
    output logic [mvaa_pkg::OUT_W-1:0]    o_twice_proj_z,
    output logic [mvaa_pkg::CNT_W-1:0]    o_triangle_total,
    output logic                          o_overflow
);
    import mvaa_pkg::*;

    localparam logic [SUM_W-1:0]     SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [CNT_W-1:0]     CNT_MAX = CNT_W'(MAX_TRIANGLES);

    // config registers
    logic             r_solid;
    logic [CFG_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid <= 1'b1;
            r_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SOLID: r_solid <= i_cfg_data[0];
                REG_LIMIT: r_limit <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // pipeline advances unless a result sits stalled at the output
    logic ce;
    assign ce         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !ce;

    // stage 1: edges and b x c products
    logic signed [IN_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    assign ax = coord(i_a_x);
    assign ay = coord(i_a_y);
    assign az = coord(i_a_z);
    assign bx = coord(i_b_x);
    assign by = coord(i_b_y);
    assign bz = coord(i_b_z);
    assign cx = coord(i_c_x);
    assign cy = coord(i_c_y);
    assign cz = coord(i_c_z);

    logic                   r1_vld, r1_last;
    logic signed [IN_W-1:0] r1_a [3];
    logic signed [IN_W:0]   r1_u [3];
    logic signed [IN_W:0]   r1_v [3];
    logic signed [2*IN_W-1:0] r1_p [6];

    // stage 2: normal products and b x c components
    logic                   r2_vld, r2_last;
    logic signed [IN_W-1:0] r2_a [3];
    logic signed [2*IN_W+1:0] r2_np [6];
    logic signed [2*IN_W:0]   r2_w [3];

    // stage 3: normal and triple product terms
    logic                   r3_vld, r3_last;
    logic signed [MAG_W-1:0]    r3_n [3];
    logic signed [3*IN_W:0]     r3_t [3];

    // stage 4: magnitudes and triple product
    logic                    r4_vld, r4_last;
    logic [MAG_W-1:0]        r4_m [3];
    logic signed [TRI_W-1:0] r4_tri;

    // stage 5: partial products of the squares (split 22 / 21 bits)
    logic                    r5_vld, r5_last;
    logic [MAG_W-1:0]        r5_m [3];
    logic signed [TRI_W-1:0] r5_tri;
    logic [43:0]             r5_hh [3];
    logic [42:0]             r5_hl [3];
    logic [41:0]             r5_ll [3];

    // stage 6: squares
    logic                    r6_vld, r6_last;
    logic [MAG_W-1:0]        r6_m [3];
    logic signed [TRI_W-1:0] r6_tri;
    logic [2*MAG_W-1:0]      r6_sq [3];

    // stage 7: squared length and degenerate test
    logic            r7_vld;
    logic [Q_W-1:0]  r7_q;
    t_side           r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (ce) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_last <= i_last_triangle;
            r1_a[0] <= ax;
            r1_a[1] <= ay;
            r1_a[2] <= az;
            r1_u[0] <= (IN_W+1)'(bx) - (IN_W+1)'(ax);
            r1_u[1] <= (IN_W+1)'(by) - (IN_W+1)'(ay);
            r1_u[2] <= (IN_W+1)'(bz) - (IN_W+1)'(az);
            r1_v[0] <= (IN_W+1)'(cx) - (IN_W+1)'(ax);
            r1_v[1] <= (IN_W+1)'(cy) - (IN_W+1)'(ay);
            r1_v[2] <= (IN_W+1)'(cz) - (IN_W+1)'(az);
            r1_p[0] <= by * cz;
            r1_p[1] <= bz * cy;
            r1_p[2] <= bz * cx;
            r1_p[3] <= bx * cz;
            r1_p[4] <= bx * cy;
            r1_p[5] <= by * cx;

            r2_last  <= r1_last;
            r2_a     <= r1_a;
            r2_np[0] <= r1_u[1] * r1_v[2];
            r2_np[1] <= r1_u[2] * r1_v[1];
            r2_np[2] <= r1_u[2] * r1_v[0];
            r2_np[3] <= r1_u[0] * r1_v[2];
            r2_np[4] <= r1_u[0] * r1_v[1];
            r2_np[5] <= r1_u[1] * r1_v[0];
            r2_w[0]  <= (2*IN_W+1)'(r1_p[0]) - (2*IN_W+1)'(r1_p[1]);
            r2_w[1]  <= (2*IN_W+1)'(r1_p[2]) - (2*IN_W+1)'(r1_p[3]);
            r2_w[2]  <= (2*IN_W+1)'(r1_p[4]) - (2*IN_W+1)'(r1_p[5]);

            r3_last <= r2_last;
            r3_n[0] <= MAG_W'(r2_np[0]) - MAG_W'(r2_np[1]);
            r3_n[1] <= MAG_W'(r2_np[2]) - MAG_W'(r2_np[3]);
            r3_n[2] <= MAG_W'(r2_np[4]) - MAG_W'(r2_np[5]);
            r3_t[0] <= r2_a[0] * r2_w[0];
            r3_t[1] <= r2_a[1] * r2_w[1];
            r3_t[2] <= r2_a[2] * r2_w[2];

            r4_last <= r3_last;
            for (int i = 0; i < 3; i++) begin
                r4_m[i] <= r3_n[i][MAG_W-1] ? MAG_W'(-r3_n[i]) : MAG_W'(r3_n[i]);
            end
            r4_tri <= TRI_W'(r3_t[0]) + TRI_W'(r3_t[1]) + TRI_W'(r3_t[2]);

            r5_last <= r4_last;
            r5_m    <= r4_m;
            r5_tri  <= r4_tri;
            for (int i = 0; i < 3; i++) begin
                r5_hh[i] <= r4_m[i][42:21] * r4_m[i][42:21];
                r5_hl[i] <= r4_m[i][42:21] * r4_m[i][20:0];
                r5_ll[i] <= r4_m[i][20:0] * r4_m[i][20:0];
            end

            r6_last <= r5_last;
            r6_m    <= r5_m;
            r6_tri  <= r5_tri;
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= ((2*MAG_W)'(r5_hh[i]) << 42) + ((2*MAG_W)'(r5_hl[i]) << 22)
                          + (2*MAG_W)'(r5_ll[i]);
            end

            r7_q           <= Q_W'(r6_sq[0]) + Q_W'(r6_sq[1]) + Q_W'(r6_sq[2]);
            r7_side.mx     <= r6_m[0];
            r7_side.my     <= r6_m[1];
            r7_side.mz     <= r6_m[2];
            r7_side.triple <= r6_tri;
            r7_side.last   <= r6_last;
            r7_side.proj   <= ((Q_W'(r6_sq[0]) + Q_W'(r6_sq[1]) + Q_W'(r6_sq[2]))
                              > Q_W'(r_limit));
        end
    end

    // root pipeline
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    mvaa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (r7_vld),
        .i_q     (r7_q),
        .i_side  (r7_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // accumulators
    logic signed [SUM_W-1:0] r_vol;
    logic [SUM_W-1:0]        r_area, r_px, r_py, r_pz;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_sat;

    logic signed [SUM_W-1:0] n_vol;
    logic [SUM_W-1:0]        n_area, n_px, n_py, n_pz;
    logic [CNT_W-1:0]        n_cnt;
    logic                    n_sat;
    logic signed [SUM_W:0]   vol_wide;
    logic [SUM_W:0]          area_wide, px_wide, py_wide, pz_wide;
    logic [SUM_W-1:0]        vol_mag;

    always_comb begin
        n_sat    = r_sat;
        vol_wide = (SUM_W+1)'(r_vol) + (SUM_W+1)'(sq_side.triple);
        // volume saturates symmetrically at plus or minus the largest sum
        if (vol_wide > $signed({1'b0, SUM_MAX})) begin
            n_vol = SUM_MAX;
            n_sat = 1'b1;
        end else if (vol_wide < -$signed({1'b0, SUM_MAX})) begin
            n_vol = -SUM_MAX;
            n_sat = 1'b1;
        end else begin
            n_vol = vol_wide[SUM_W-1:0];
        end

        area_wide = (SUM_W+1)'(r_area) + (SUM_W+1)'(sq_root);
        if (area_wide > (SUM_W+1)'(SUM_MAX)) begin
            n_area = SUM_MAX;
            n_sat  = 1'b1;
        end else begin
            n_area = area_wide[SUM_W-1:0];
        end

        px_wide = (SUM_W+1)'(r_px) + (SUM_W+1)'(sq_side.mx);
        py_wide = (SUM_W+1)'(r_py) + (SUM_W+1)'(sq_side.my);
        pz_wide = (SUM_W+1)'(r_pz) + (SUM_W+1)'(sq_side.mz);
        n_px = r_px;
        n_py = r_py;
        n_pz = r_pz;
        // near-degenerate triangles skip the projected sums
        if (sq_side.proj) begin
            if (px_wide > (SUM_W+1)'(SUM_MAX)) begin
                n_px  = SUM_MAX;
                n_sat = 1'b1;
            end else begin
                n_px = px_wide[SUM_W-1:0];
            end
            if (py_wide > (SUM_W+1)'(SUM_MAX)) begin
                n_py  = SUM_MAX;
                n_sat = 1'b1;
            end else begin
                n_py = py_wide[SUM_W-1:0];
            end
            if (pz_wide > (SUM_W+1)'(SUM_MAX)) begin
                n_pz  = SUM_MAX;
                n_sat = 1'b1;
            end else begin
                n_pz = pz_wide[SUM_W-1:0];
            end
        end

        // count stops at its ceiling without raising overflow
        n_cnt   = (r_cnt < CNT_MAX) ? r_cnt + CNT_W'(1) : r_cnt;
        vol_mag = n_vol[SUM_W-1] ? SUM_W'(-n_vol) : SUM_W'(n_vol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol       <= '0;
            r_area      <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_pz        <= '0;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (ce) begin
            o_out_valid <= sq_vld && sq_side.last;
            if (sq_vld) begin
                if (sq_side.last) begin
                    // mesh done: clear for the next one
                    r_vol  <= '0;
                    r_area <= '0;
                    r_px   <= '0;
                    r_py   <= '0;
                    r_pz   <= '0;
                    r_cnt  <= '0;
                    r_sat  <= 1'b0;
                end else begin
                    r_vol  <= n_vol;
                    r_area <= n_area;
                    r_px   <= n_px;
                    r_py   <= n_py;
                    r_pz   <= n_pz;
                    r_cnt  <= n_cnt;
                    r_sat  <= n_sat;
                end
            end
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_six_volume     <= r_solid ? vol_mag[OUT_W-1:0] : '0;
            o_twice_area     <= n_area[OUT_W-1:0];
            o_twice_proj_x   <= n_px[OUT_W-1:0];
            o_twice_proj_y   <= n_py[OUT_W-1:0];
            o_twice_proj_z   <= n_pz[OUT_W-1:0];
            o_triangle_total <= n_cnt;
            o_overflow       <= n_sat;
        end
    end

    // a result always counts at least its own triangle
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_triangle_total != '0)
        else $error("result with zero triangle count");

    // each |n_x| is at most floor(sqrt(|n|^2)) unless something saturated
    a_proj_le_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_overflow) |->
            (o_twice_proj_x <= o_twice_area && o_twice_proj_y <= o_twice_area
             && o_twice_proj_z <= o_twice_area))
        else $error("projected sum exceeds area sum");

    // volume is forced to zero when the solid flag is off
    a_solid_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_solid) |-> o_six_volume == '0)
        else $error("volume reported with solid flag off");

endmodule
